// ===== hdl/cla_pkg.sv =====
// Shared types and constants for the CR LF line assembler.
// No dependencies; imported by every module of the block.
package cla_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 9;
   localparam int LEN_W  = 9;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   localparam logic [CMD_W-1:0] CMD_RX      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

   typedef enum logic [1:0] {
      OP_RX,
      OP_READ,
      OP_RELEASE,
      OP_NONE
   } op_type;

   // One classified request as it waits between front and back
   typedef struct packed {
      op_type            op;
      logic              is_cr;
      logic              is_lf;
      logic [BYTE_W-1:0] rx_byte;
      logic [IDX_W-1:0]  read_index;
   } item_type;

endpackage

// ===== hdl/cla_front.sv =====
// Front end of the line assembler: accepts request transfers, decodes the
// command and the CR/LF character classes, and queues them for the back end.
// Depends on cla_pkg.
module cla_front
   import cla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  q_valid,
   output item_type              q_item,
   input  logic                  q_pop
);

   localparam int DEPTH = 2;

   item_type       slot_ff [DEPTH];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   item_type       item;
   logic           push;

   always_comb begin
      item.rx_byte    = req_tdata[BYTE_W-1:0];
      item.read_index = req_tdata[BYTE_W+IDX_W-1:BYTE_W];
      item.is_cr      = (req_tdata[BYTE_W-1:0] == CH_CR);
      item.is_lf      = (req_tdata[BYTE_W-1:0] == CH_LF);
      case (req_tuser)
         CMD_RX:      item.op = OP_RX;
         CMD_READ:    item.op = OP_READ;
         CMD_RELEASE: item.op = OP_RELEASE;
         default:     item.op = OP_NONE;
      endcase
   end

   assign req_tready = (fill_ff != 2'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== hdl/cla_back.sv =====
// Back end of the line assembler: line state, the banked line store and the
// response register. Takes classified items from the front-end queue.
// Depends on cla_pkg.
module cla_back
   import cla_pkg::*;
#(
   parameter int LINE_CAPACITY = 512
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W      = $clog2(LINE_CAPACITY);
   localparam int BANK_DEPTH = (LINE_CAPACITY + 1) / 2;
   localparam int ROW_W      = $clog2(BANK_DEPTH);
   localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(LINE_CAPACITY - 1);

   // Even and odd addresses live in separate banks so that the held-back CR
   // and the byte after it can be written in the same cycle.
   logic [BYTE_W-1:0] mem_even [BANK_DEPTH];
   logic [BYTE_W-1:0] mem_odd  [BANK_DEPTH];

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              cr_ff, cr_in;
   logic              done_ff, done_in;
   logic              out_valid_ff, out_valid_in;
   logic              completed_ff, completed_in;
   logic              discarded_ff, discarded_in;
   logic              hit_ff, hit_in;
   logic              sel_ff;
   logic [BYTE_W-1:0] rd_even_ff, rd_odd_ff;

   logic              advance;
   logic [CNT_W-1:0]  nxt, base;
   logic              wr0_en, wr1_en;
   logic [CNT_W-1:0]  wr0_addr, wr1_addr;
   logic [BYTE_W-1:0] wr0_data, wr1_data;
   logic              ev_we, od_we;
   logic [ROW_W-1:0]  ev_row, od_row, rd_row;
   logic [BYTE_W-1:0] ev_data, od_data;
   logic [CMP_W-1:0]  idx_ext;
   logic [BYTE_W-1:0] read_data;

   assign advance = q_valid && (!out_valid_ff || rsp_tready);
   assign q_pop   = advance;
   assign idx_ext = CMP_W'(q_item.read_index);
   assign rd_row  = ROW_W'(idx_ext >> 1);
   assign nxt     = cnt_ff + 1'b1;

   always_comb begin
      cnt_in       = cnt_ff;
      cr_in        = cr_ff;
      done_in      = done_ff;
      completed_in = 1'b0;
      discarded_in = 1'b0;
      hit_in       = 1'b0;
      base         = cnt_ff;
      wr0_en       = 1'b0;
      wr0_addr     = cnt_ff;
      wr0_data     = q_item.rx_byte;
      wr1_en       = 1'b0;
      wr1_addr     = cnt_ff;
      wr1_data     = q_item.rx_byte;
      case (q_item.op)
         OP_RX: begin
            if (!done_ff) begin
               if (cr_ff) begin
                  if (q_item.is_lf) begin
                     if (cnt_ff != '0) begin
                        done_in      = 1'b1;
                        completed_in = 1'b1;
                     end else begin
                        cr_in = 1'b0;
                     end
                  end else begin
                     // store the held-back CR first; a full line drops
                     if (cnt_ff == LAST) begin
                        discarded_in = 1'b1;
                        base         = '0;
                     end else begin
                        wr0_en   = 1'b1;
                        wr0_data = CH_CR;
                        base     = nxt;
                     end
                     if (q_item.is_cr) begin
                        cr_in  = 1'b1;
                        cnt_in = base;
                     end else begin
                        cr_in = 1'b0;
                        if (base == LAST) begin
                           discarded_in = 1'b1;
                           cnt_in       = '0;
                        end else begin
                           wr1_en   = 1'b1;
                           wr1_addr = base;
                           cnt_in   = base + 1'b1;
                        end
                     end
                  end
               end else if (q_item.is_cr) begin
                  cr_in = 1'b1;
               end else if (cnt_ff == LAST) begin
                  discarded_in = 1'b1;
                  cnt_in       = '0;
               end else begin
                  wr0_en = 1'b1;
                  cnt_in = nxt;
               end
            end
         end
         OP_READ: begin
            hit_in = (idx_ext < CMP_W'(cnt_ff));
         end
         OP_RELEASE: begin
            done_in = 1'b0;
            cr_in   = 1'b0;
            cnt_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Route the up to two writes to their banks; they never share a bank.
   always_comb begin
      ev_we   = (wr0_en && !wr0_addr[0]) || (wr1_en && !wr1_addr[0]);
      od_we   = (wr0_en && wr0_addr[0]) || (wr1_en && wr1_addr[0]);
      ev_row  = (wr0_en && !wr0_addr[0]) ? ROW_W'(wr0_addr >> 1) : ROW_W'(wr1_addr >> 1);
      ev_data = (wr0_en && !wr0_addr[0]) ? wr0_data : wr1_data;
      od_row  = (wr0_en && wr0_addr[0]) ? ROW_W'(wr0_addr >> 1) : ROW_W'(wr1_addr >> 1);
      od_data = (wr0_en && wr0_addr[0]) ? wr0_data : wr1_data;
   end

   always_ff @(posedge clock) begin
      if (advance && ev_we) begin
         mem_even[ev_row] <= ev_data;
      end
      if (advance && hit_in) begin
         rd_even_ff <= mem_even[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (advance && od_we) begin
         mem_odd[od_row] <= od_data;
      end
      if (advance && hit_in) begin
         rd_odd_ff <= mem_odd[rd_row];
      end
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cr_ff        <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cnt_ff  <= cnt_in;
            cr_ff   <= cr_in;
            done_ff <= done_in;
         end
      end
   end

   // hold the flags while the response waits
   always_ff @(posedge clock) begin
      if (advance) begin
         completed_ff <= completed_in;
         discarded_ff <= discarded_in;
         hit_ff       <= hit_in;
         sel_ff       <= q_item.read_index[0];
      end
   end

   assign read_data  = hit_ff ? (sel_ff ? rd_odd_ff : rd_even_ff) : '0;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, discarded_ff, completed_ff, cr_ff, read_data,
                        LEN_W'(cnt_ff), done_ff};

endmodule

// ===== hdl/crlf_line_assembler_top.sv =====
// Top level of the CR LF line assembler: front-end decode queue feeding the
// back end that keeps the line state and store. Depends on cla_pkg,
// cla_front and cla_back.
//
//  channel | ports                          | payload (low bit first)
//  --------+--------------------------------+-----------------------------------
//  request | req_tvalid/tready/tdata/tuser  | tuser: cmd; tdata: rx_byte,
//          |                                |   read_index, zero pad
//  result  | rsp_tvalid/tready/tdata        | line_ready, line_length, read_data,
//          |                                |   cr_pending, line_completed,
//          |                                |   line_discarded, zero pad
//
// One transfer per cycle sustained while results are taken; a request passes
// the queue slot, then the state update with the store access, to the result.
// The line store is split into even and odd banks so a held-back CR and the
// next byte are written in the same cycle. Synchronous reset clears line state and
// the queue; the store needs no clearing. A stalled result holds the back end
// while the two-entry queue keeps taking requests until both entries fill.
module crlf_line_assembler_top
   import cla_pkg::*;
#(
   parameter int LINE_CAPACITY = 512
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] rx_byte, [16:8] read_index
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [0] line_ready, [9:1] line_length,
                                             // [17:10] read_data, [18] cr_pending,
                                             // [19] line_completed,
                                             // [20] line_discarded
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   cla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   cla_back #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
